// ----- src/fpa_pkg.sv -----
// shared types and codes for the q24.8 fixed-point alu
package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_FINT = 4'd4,
    CMD_TINT = 4'd5,
    CMD_MIN  = 4'd6,
    CMD_MAX  = 4'd7,
    CMD_INC  = 4'd8,
    CMD_DEC  = 4'd9,
    CMD_CMP  = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // per-transaction side data that rides along the divider row
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] res;
    status_t     status;
    logic        less;
    logic        equal;
    logic        neg;
  } info_t;

endpackage

// ----- src/fpa_front.sv -----
// operand capture, multiplier and all operations but the divide
module fpa_front #(
  parameter int FRACTION_BITS = 8,
  parameter int DQW           = 32 + FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [3:0]         in_command,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               valid_o,
  output fpa_pkg::info_t     info_o,
  output logic [31:0]        rem_o,
  output logic [DQW-1:0]     dq_o,
  output logic [31:0]        dv_o
);

  localparam logic [31:0] SCALE_M1 = 32'((64'd1 << FRACTION_BITS) - 64'd1);

  logic               p_valid_r;
  fpa_pkg::cmd_t      p_cmd_r;
  logic signed [31:0] p_a_r, p_b_r;
  logic signed [63:0] p_prod_r;
  logic signed [63:0] prod_nxt;

  logic               valid_r;
  fpa_pkg::info_t     info_r, info_nxt;
  logic [31:0]        dv_r, dv_nxt;
  logic [DQW-1:0]     dq_r, dq_nxt;

  logic signed [32:0] sum, diff, incr, decr;
  logic signed [63:0] mul_sh, mul_t, fi;
  logic signed [31:0] ti;
  logic [31:0]        abs_a;
  logic               lt;

  function automatic logic signed [63:0] p_a_nxt_mul(input logic signed [31:0] x,
                                                     input logic signed [31:0] y);
    logic signed [63:0] r;
    r = x * y;
    return r;
  endfunction

  // first stage: capture and multiply
  assign prod_nxt = p_a_nxt_mul(in_operand_a, in_operand_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_valid;
    end
    p_cmd_r  <= fpa_pkg::cmd_t'(in_command);
    p_a_r    <= in_operand_a;
    p_b_r    <= in_operand_b;
    p_prod_r <= prod_nxt;
  end

  // second stage: finish everything but the divide
  always_comb begin
    sum    = 33'(p_a_r) + 33'(p_b_r);
    diff   = 33'(p_a_r) - 33'(p_b_r);
    incr   = 33'(p_a_r) + 33'sd1;
    decr   = 33'(p_a_r) - 33'sd1;
    mul_sh = p_prod_r >>> FRACTION_BITS;
    mul_t  = mul_sh + 64'(p_prod_r[63] && (|p_prod_r[FRACTION_BITS-1:0]));
    fi     = 64'(p_a_r) <<< FRACTION_BITS;
    ti     = (p_a_r + (p_a_r[31] ? $signed(SCALE_M1) : 32'sd0)) >>> FRACTION_BITS;
    abs_a  = p_a_r[31] ? 32'(-p_a_r) : 32'(p_a_r);
    lt     = p_a_r < p_b_r;

    info_nxt.cmd    = p_cmd_r;
    info_nxt.res    = '0;
    info_nxt.status = fpa_pkg::ST_OK;
    info_nxt.less   = lt;
    info_nxt.equal  = p_a_r == p_b_r;
    info_nxt.neg    = p_a_r[31] ^ p_b_r[31];

    unique case (p_cmd_r)
      fpa_pkg::CMD_ADD: begin
        info_nxt.res = sum[31:0];
        if (sum[32] != sum[31]) info_nxt.status = fpa_pkg::ST_OVF;
      end
      fpa_pkg::CMD_SUB: begin
        info_nxt.res = diff[31:0];
        if (diff[32] != diff[31]) info_nxt.status = fpa_pkg::ST_OVF;
      end
      fpa_pkg::CMD_INC: begin
        info_nxt.res = incr[31:0];
        if (incr[32] != incr[31]) info_nxt.status = fpa_pkg::ST_OVF;
      end
      fpa_pkg::CMD_DEC: begin
        info_nxt.res = decr[31:0];
        if (decr[32] != decr[31]) info_nxt.status = fpa_pkg::ST_OVF;
      end
      fpa_pkg::CMD_MUL: begin
        if (mul_t[63:31] == {33{mul_t[31]}}) info_nxt.res = mul_t[31:0];
        else info_nxt.status = fpa_pkg::ST_OVF;
      end
      fpa_pkg::CMD_DIV: begin
        if (p_b_r == 32'sd0) info_nxt.status = fpa_pkg::ST_DZ;
      end
      fpa_pkg::CMD_FINT: begin
        if (fi[63:31] == {33{fi[31]}}) info_nxt.res = fi[31:0];
        else info_nxt.status = fpa_pkg::ST_OVF;
      end
      fpa_pkg::CMD_TINT: info_nxt.res = ti;
      fpa_pkg::CMD_MIN:  info_nxt.res = lt ? p_a_r : p_b_r;
      fpa_pkg::CMD_MAX:  info_nxt.res = (p_a_r > p_b_r) ? p_a_r : p_b_r;
      default:           info_nxt.res = '0;
    endcase

    dq_nxt = {abs_a, {FRACTION_BITS{1'b0}}};
    dv_nxt = p_b_r[31] ? 32'(-p_b_r) : 32'(p_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= p_valid_r;
    end
    info_r <= info_nxt;
    dq_r   <= dq_nxt;
    dv_r   <= dv_nxt;
  end

  assign valid_o = valid_r;
  assign info_o  = info_r;
  assign rem_o   = '0;
  assign dq_o    = dq_r;
  assign dv_o    = dv_r;

endmodule

// ----- src/fpa_cell.sv -----
// one restoring-division cell: produces one quotient bit per transaction
module fpa_cell #(
  parameter int DQW = 40
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  fpa_pkg::info_t info_i,
  input  logic [31:0]    rem_i,
  input  logic [DQW-1:0] dq_i,
  input  logic [31:0]    dv_i,
  output logic           valid_o,
  output fpa_pkg::info_t info_o,
  output logic [31:0]    rem_o,
  output logic [DQW-1:0] dq_o,
  output logic [31:0]    dv_o
);

  logic           valid_r;
  fpa_pkg::info_t info_r;
  logic [31:0]    rem_r, rem_nxt;
  logic [DQW-1:0] dq_r, dq_nxt;
  logic [31:0]    dv_r;
  logic [32:0]    shifted, trial;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem_i, dq_i[DQW-1]};
    trial   = shifted - {1'b0, dv_i};
    if (!trial[32]) begin
      rem_nxt = trial[31:0];
    end else begin
      rem_nxt = shifted[31:0];
    end
    dq_nxt = {dq_i[DQW-2:0], ~trial[32]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    info_r <= info_i;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
    dv_r   <= dv_i;
  end

  assign valid_o = valid_r;
  assign info_o  = info_r;
  assign rem_o   = rem_r;
  assign dq_o    = dq_r;
  assign dv_o    = dv_r;

endmodule

// ----- src/fixed_point_q24_8_alu.sv -----
// top level of the signed q24.8 fixed-point alu
// usage:
//   drive in_command, in_operand_a and in_operand_b with start high; a
//   transaction is taken at each rising edge with start high and busy low.
//   busy is always low, so one transaction may be issued every cycle.
//   each result appears on the out_ ports for exactly one cycle with
//   out_strobe high, in issue order, after the transaction has passed the
//   front stages, the row of division cells and the result register.
//   the latency is the same for every command: the divider is a row of
//   32 + FRACTION_BITS cells, one quotient bit per cell, and the other
//   commands ride along the row with it.
//   throughput is one transaction per cycle.
//   the multiplier sits in the first stage, truncation and range checks
//   in the second; the divide sign fix-up and range check in the last.
//   the receiver cannot stall; results are never held back.
//   synchronous active-low reset clears all valid flags; transactions in
//   flight are dropped and no strobe appears until new work arrives.
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_command,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_strobe,
  output logic signed [31:0] out_result_value,
  output logic               out_a_less,
  output logic               out_a_equal,
  output logic [1:0]         out_status
);

  localparam int DQW = 32 + FRACTION_BITS;

  logic           valid_w [0:DQW];
  fpa_pkg::info_t info_w  [0:DQW];
  logic [31:0]    rem_w   [0:DQW];
  logic [DQW-1:0] dq_w    [0:DQW];
  logic [31:0]    dv_w    [0:DQW];

  logic               out_strobe_r;
  logic [31:0]        out_res_r, res_nxt;
  logic               out_less_r, out_equal_r;
  fpa_pkg::status_t   out_status_r, status_nxt;
  logic [31:0]        q_lo;
  logic               q_fits;

  assign busy = 1'b0;

  // operand stages
  fpa_front #(.FRACTION_BITS(FRACTION_BITS), .DQW(DQW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start),
    .in_command(in_command), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .valid_o(valid_w[0]), .info_o(info_w[0]), .rem_o(rem_w[0]),
    .dq_o(dq_w[0]), .dv_o(dv_w[0])
  );

  // row of division cells
  for (genvar i = 0; i < DQW; i++) begin : g_cell
    fpa_cell #(.DQW(DQW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .valid_i(valid_w[i]), .info_i(info_w[i]), .rem_i(rem_w[i]),
      .dq_i(dq_w[i]), .dv_i(dv_w[i]),
      .valid_o(valid_w[i+1]), .info_o(info_w[i+1]), .rem_o(rem_w[i+1]),
      .dq_o(dq_w[i+1]), .dv_o(dv_w[i+1])
    );
  end

  // divide sign correction and range check
  always_comb begin
    q_lo = dq_w[DQW][31:0];
    if (info_w[DQW].neg) begin
      q_fits = (dq_w[DQW][DQW-1:32] == '0) && (q_lo <= 32'h8000_0000);
    end else begin
      q_fits = (dq_w[DQW][DQW-1:32] == '0) && (q_lo <= 32'h7fff_ffff);
    end
    res_nxt    = info_w[DQW].res;
    status_nxt = info_w[DQW].status;
    if (info_w[DQW].cmd == fpa_pkg::CMD_DIV && info_w[DQW].status == fpa_pkg::ST_OK) begin
      if (q_fits) begin
        res_nxt = info_w[DQW].neg ? 32'(-q_lo) : q_lo;
      end else begin
        res_nxt    = '0;
        status_nxt = fpa_pkg::ST_OVF;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= valid_w[DQW];
    end
    out_res_r    <= res_nxt;
    out_less_r   <= info_w[DQW].less;
    out_equal_r  <= info_w[DQW].equal;
    out_status_r <= status_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_result_value = out_res_r;
  assign out_a_less       = out_less_r;
  assign out_a_equal      = out_equal_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_status != 2'd3)
    else $error("reserved status code on result");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == fpa_pkg::ST_DZ |-> out_result_value == 32'sd0)
    else $error("divide by zero result not zero");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_a_less && out_a_equal))
    else $error("less and equal flags both set");
`endif

endmodule

// ----- sim/fixed_point_q24_8_alu_checker.sv -----
// result checker for the q24.8 fixed-point alu: predicts and compares each transaction
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [3:0]         in_command,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  input  logic               out_strobe,
  input  logic signed [31:0] out_result_value,
  input  logic               out_a_less,
  input  logic               out_a_equal,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 pending
);
  localparam int FRAC = 8;

  typedef struct packed {
    logic [31:0] value;
    logic        less;
    logic        equal;
    logic [1:0]  status;
  } alu_result_t;

  alu_result_t alu_results_due[$];

  function automatic logic fits_s32(longint v);
    return v >= -64'sd2147483648 && v <= 64'sd2147483647;
  endfunction

  // exact 64-bit arithmetic, truncating toward zero as the integer divide does
  function automatic alu_result_t compute_alu(logic [3:0] op, logic signed [31:0] a32,
                                              logic signed [31:0] b32);
    alu_result_t r;
    longint a;
    longint b;
    longint t;
    a = a32;
    b = b32;
    r = '0;
    r.less = a < b;
    r.equal = a == b;
    case (op)
      fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC: begin
        if (op == fpa_pkg::CMD_ADD) t = a + b;
        else if (op == fpa_pkg::CMD_SUB) t = a - b;
        else if (op == fpa_pkg::CMD_INC) t = a + 1;
        else t = a - 1;
        if (!fits_s32(t)) r.status = fpa_pkg::ST_OVF;
        r.value = t[31:0];
      end
      fpa_pkg::CMD_MUL: begin
        t = (a * b) / (64'sd1 << FRAC);
        if (fits_s32(t)) r.value = t[31:0];
        else r.status = fpa_pkg::ST_OVF;
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) r.status = fpa_pkg::ST_DZ;
        else begin
          t = (a * (64'sd1 << FRAC)) / b;
          if (fits_s32(t)) r.value = t[31:0];
          else r.status = fpa_pkg::ST_OVF;
        end
      end
      fpa_pkg::CMD_FINT: begin
        t = a * (64'sd1 << FRAC);
        if (fits_s32(t)) r.value = t[31:0];
        else r.status = fpa_pkg::ST_OVF;
      end
      fpa_pkg::CMD_TINT: begin
        t = a / (64'sd1 << FRAC);
        r.value = t[31:0];
      end
      fpa_pkg::CMD_MIN: r.value = (a < b) ? a32 : b32;
      fpa_pkg::CMD_MAX: r.value = (a > b) ? a32 : b32;
      default: r.value = '0;
    endcase
    return r;
  endfunction

  assign pending = alu_results_due.size();

  // predict on acceptance, compare on strobe
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      alu_results_due.delete();
      fail_count <= 0;
    end else begin
      if (out_strobe) begin
        if (alu_results_due.size() == 0) begin
          if (fail_count < 10)
            $display("error: unexpected result value=%h status=%0d", out_result_value, out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = alu_results_due.pop_front();
          if (out_result_value !== want.value || out_a_less !== want.less ||
              out_a_equal !== want.equal || out_status !== want.status) begin
            if (fail_count < 10)
              $display("mismatch: exp v=%h l=%b e=%b s=%0d got v=%h l=%b e=%b s=%0d",
                       want.value, want.less, want.equal, want.status,
                       out_result_value, out_a_less, out_a_equal, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        alu_results_due.push_back(compute_alu(in_command, in_operand_a, in_operand_b));
    end
  end
endmodule

// ----- sim/fixed_point_q24_8_alu_tb.sv -----
// testbench top for the q24.8 fixed-point alu: stimulus and verdict
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_tb;

  localparam int LATENCY = 43;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_command = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_strobe;
  logic signed [31:0] out_result_value;
  logic out_a_less;
  logic out_a_equal;
  logic [1:0] out_status;
  int fail_count;
  int pending;
  int idle_cycles = 0;

  fixed_point_q24_8_alu dut (.*);
  fixed_point_q24_8_alu_checker chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL fixed_point_q24_8_alu");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h100 : 32'hffffff00;
      4, 5: return $signed($urandom_range(0, 8191)) - 4096;
      6: return $signed($urandom_range(0, 2097151)) - 1048576;
      default: return $urandom();
    endcase
  endfunction

  // hold one transaction until taken, with random gaps unless quiet
  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b, bit quiet);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_command <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int waited;
    logic [31:0] a;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes and special cases
    send_op(fpa_pkg::CMD_ADD, 32'h7fffffff, 32'h1, 1'b0);
    send_op(fpa_pkg::CMD_SUB, 32'h80000000, 32'h1, 1'b0);
    send_op(fpa_pkg::CMD_INC, 32'h7fffffff, 32'h0, 1'b0);
    send_op(fpa_pkg::CMD_DEC, 32'h80000000, 32'h0, 1'b0);
    send_op(fpa_pkg::CMD_MUL, 32'h7fffffff, 32'h7fffffff, 1'b0);
    send_op(fpa_pkg::CMD_MUL, 32'hfffffe80, 32'h00000180, 1'b0);
    send_op(fpa_pkg::CMD_DIV, 32'h00000100, 32'h0, 1'b0);
    send_op(fpa_pkg::CMD_DIV, 32'h80000000, 32'hffffffff, 1'b0);
    send_op(fpa_pkg::CMD_DIV, 32'hfffffc00, 32'h00000300, 1'b0);
    send_op(fpa_pkg::CMD_FINT, 32'h007fffff, 32'h0, 1'b0);
    send_op(fpa_pkg::CMD_FINT, 32'h00800000, 32'h0, 1'b0);
    send_op(fpa_pkg::CMD_FINT, 32'hff800000, 32'h0, 1'b0);
    send_op(fpa_pkg::CMD_TINT, 32'hfffffe80, 32'h0, 1'b0);
    send_op(fpa_pkg::CMD_TINT, 32'h80000000, 32'h0, 1'b0);
    send_op(fpa_pkg::CMD_MIN, 32'h5, 32'h5, 1'b0);
    send_op(fpa_pkg::CMD_MAX, 32'h80000000, 32'h7fffffff, 1'b0);
    send_op(fpa_pkg::CMD_CMP, 32'hffffffff, 32'h1, 1'b0);
    send_op(4'd11, 32'h3, 32'h2, 1'b0);
    send_op(4'd15, 32'hffffffff, 32'hffffffff, 1'b0);

    // random, with a burst of back-to-back transactions in the middle
    for (int i = 0; i < 1250; i++) begin
      a = pick_operand();
      send_op(4'($urandom_range(0, 15)), a,
              ($urandom_range(0, 7) == 0) ? a : pick_operand(),
              i >= 500 && i < 700);
    end
    start <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 10 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS fixed_point_q24_8_alu");
    else $display("FAIL fixed_point_q24_8_alu");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/fpa_pkg.sv
src/fpa_front.sv
src/fpa_cell.sv
src/fixed_point_q24_8_alu.sv
sim/fixed_point_q24_8_alu_checker.sv
sim/fixed_point_q24_8_alu_tb.sv
